// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the record checker.
// Depends on nothing; the SYNTH macro turns the checks into empty text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FPRC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPRC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FPRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/fprc_pkg.sv -----
// Types, codes and the CRC32 byte update for the record checker.
// Used by the front, queue, back and top level; depends on nothing.
`default_nettype none
package fprc_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_GET_OK    = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_NAME  = 3'd4;
  localparam logic [2:0] ST_NO_UPLOAD = 3'd5;
  localparam logic [2:0] ST_MISMATCH  = 3'd6;

  localparam logic [31:0] MAGIC_FETCH  = 32'h4547_4642;
  localparam logic [31:0] MAGIC_ABORT  = 32'h4143_4642;
  localparam logic [31:0] MAGIC_START  = 32'h5350_4642;
  localparam logic [31:0] MAGIC_END    = 32'h4550_4642;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [2:0] {
    CLS_NONE, CLS_GET, CLS_CANCEL, CLS_START, CLS_END, CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {RESP_NONE, RESP_GET, RESP_START, RESP_END} resp_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        magic;
    logic        magic_init;
    cls_t        cls;
    logic        body;
    logic        last;
    resp_t       resp;
    logic [2:0]  name_st;
    logic        end_short;
    logic [31:0] exp_size;
    logic [31:0] exp_crc;
  } entry_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fprc_front.sv -----
// Front part: tracks the record position, classifies the magic word and checks names.
// Depends on fprc_pkg; produces one queue entry for every accepted byte.
`default_nettype none
module fprc_front #(
  parameter int MAX_NAME_LEN = 192
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first_of_record,
  input  wire logic            last_of_record,
  output fprc_pkg::entry_t     entry
);
  import fprc_pkg::*;

  logic [15:0] rec_index;
  logic [23:0] magic;
  cls_t        kind;
  logic [15:0] name_len;
  logic [31:0] exp_size;
  logic [31:0] exp_crc;
  logic [2:0]  flags;

  logic [15:0] pos;
  cls_t        kind_cur, kind_next;
  logic [15:0] nl_cur, nl_next;
  logic [23:0] magic_cur, magic_next;
  logic [31:0] size_cur, size_next, crc_cur, crc_next;
  logic [2:0]  flags_cur, flags_next;
  logic [16:0] len;
  logic [31:0] magic_word;
  logic [15:0] name_off;
  logic [2:0]  name_st;
  logic        named;

  always_comb begin
    pos       = first_of_record ? 16'd0 : rec_index;
    kind_cur  = first_of_record ? CLS_NONE : kind;
    nl_cur    = first_of_record ? 16'd0 : name_len;
    magic_cur = first_of_record ? 24'd0 : magic;
    size_cur  = first_of_record ? 32'd0 : exp_size;
    crc_cur   = first_of_record ? 32'd0 : exp_crc;
    flags_cur = first_of_record ? 3'd0 : flags;

    kind_next  = kind_cur;
    nl_next    = nl_cur;
    magic_next = magic_cur;
    size_next  = size_cur;
    crc_next   = crc_cur;
    flags_next = flags_cur;
    magic_word = {data_byte, magic_cur};
    name_off   = pos - 16'd6;
    named      = (kind_cur == CLS_GET) || (kind_cur == CLS_START);

    if (pos < 16'd3) begin
      magic_next[pos[1:0]*8 +: 8] = data_byte;
    end else if (pos == 16'd3) begin
      if (magic_word == MAGIC_FETCH) kind_next = CLS_GET;
      else if (magic_word == MAGIC_ABORT) kind_next = CLS_CANCEL;
      else if (magic_word == MAGIC_START) kind_next = CLS_START;
      else if (magic_word == MAGIC_END) kind_next = CLS_END;
      else kind_next = CLS_OTHER;
    end else if (named) begin
      if (pos == 16'd4) begin
        nl_next = {8'd0, data_byte};
      end else if (pos == 16'd5) begin
        nl_next = {data_byte, nl_cur[7:0]};
      end else if (name_off < nl_cur && !flags_cur[2]) begin
        if (data_byte == 8'd0) begin
          flags_next[2] = 1'b1;
        end else begin
          if (data_byte == CH_DOT) begin
            if (flags_cur[1]) flags_next[0] = 1'b1;
            flags_next[1] = 1'b1;
          end else begin
            flags_next[1] = 1'b0;
          end
          if (kind_cur == CLS_START && (data_byte == CH_SLASH || data_byte == CH_BSL)) begin
            flags_next[0] = 1'b1;
          end
        end
      end
    end else if (kind_cur == CLS_END) begin
      if (pos < 16'd8) size_next[pos[1:0]*8 +: 8] = data_byte;
      else if (pos < 16'd12) crc_next[pos[1:0]*8 +: 8] = data_byte;
    end

    len = {1'b0, pos} + 17'd1;
    if (len < 17'd6) name_st = ST_TOO_SHORT;
    else if (nl_next == 16'd0 || nl_next > 16'(MAX_NAME_LEN)
             || len < 17'd6 + {1'b0, nl_next}) name_st = ST_BAD_LEN;
    else if (flags_next[0]) name_st = ST_BAD_NAME;
    else name_st = (kind_next == CLS_GET) ? ST_GET_OK : ST_OK;

    entry.data       = data_byte;
    entry.magic      = pos < 16'd4;
    entry.magic_init = pos == 16'd0;
    entry.cls        = (pos == 16'd3) ? kind_next : CLS_NONE;
    entry.body       = (pos > 16'd3) && (kind_cur == CLS_OTHER);
    entry.last       = last_of_record;
    case (kind_next)
      CLS_GET:   entry.resp = RESP_GET;
      CLS_START: entry.resp = RESP_START;
      CLS_END:   entry.resp = RESP_END;
      default:   entry.resp = RESP_NONE;
    endcase
    entry.name_st   = name_st;
    entry.end_short = len < 17'd12;
    entry.exp_size  = size_next;
    entry.exp_crc   = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_index <= '0;
      kind      <= CLS_NONE;
      magic     <= '0;
      name_len  <= '0;
      exp_size  <= '0;
      exp_crc   <= '0;
      flags     <= '0;
    end else if (accept) begin
      if (last_of_record) begin
        rec_index <= '0;
        kind      <= CLS_NONE;
        magic     <= '0;
        name_len  <= '0;
        exp_size  <= '0;
        exp_crc   <= '0;
        flags     <= '0;
      end else begin
        rec_index <= (pos == 16'hFFFF) ? pos : pos + 16'd1;
        kind      <= kind_next;
        magic     <= magic_next;
        name_len  <= nl_next;
        exp_size  <= size_next;
        exp_crc   <= crc_next;
        flags     <= flags_next;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/fprc_queue.sv -----
// Two-entry queue of classified bytes between the front and back parts.
// Depends on fprc_pkg for the entry type.
`default_nettype none
module fprc_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire fprc_pkg::entry_t wr_entry,
  input  wire logic        pop,
  output fprc_pkg::entry_t rd_entry,
  output logic             full,
  output logic             not_empty
);
  import fprc_pkg::*;

  entry_t      slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/fprc_back.sv -----
// Back part: upload state, CRC32 and byte count, and the registered status output.
// Depends on fprc_pkg; consumes entries from the queue.
`default_nettype none
module fprc_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pop,
  input  wire fprc_pkg::entry_t ent,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      byte_count,
  output logic [31:0]      crc_value
);
  import fprc_pkg::*;

  logic        active;
  logic        is_data;
  logic [31:0] running_crc;
  logic [31:0] count;
  logic [31:0] spec;

  logic        active_next, is_data_next, emit;
  logic [31:0] crc_a, cnt_a, crc_next, count_next, spec_next;
  logic [2:0]  st;

  assign room = !out_valid || !out_stall;

  always_comb begin
    crc_a        = running_crc;
    cnt_a        = count;
    active_next  = active;
    is_data_next = is_data;
    spec_next    = crc_feed(ent.magic_init ? running_crc : spec, ent.data);

    case (ent.cls) inside
      CLS_OTHER: begin
        is_data_next = active;
        if (active) begin
          crc_a = spec_next;
          cnt_a = count + 32'd4;
        end
      end
      CLS_CANCEL, CLS_START: begin
        is_data_next = 1'b0;
        active_next  = 1'b0;
        crc_a        = '0;
        cnt_a        = '0;
      end
      CLS_GET, CLS_END: is_data_next = 1'b0;
      default: ;
    endcase
    if (ent.body && is_data) begin
      crc_a = crc_feed(running_crc, ent.data);
      cnt_a = count + 32'd1;
    end

    crc_next   = crc_a;
    count_next = cnt_a;
    emit       = ent.last && ent.resp != RESP_NONE;
    st         = ent.name_st;
    case (ent.resp)
      RESP_START: begin
        if (ent.name_st == ST_OK) begin
          active_next = 1'b1;
          crc_next    = '0;
          count_next  = '0;
        end
      end
      RESP_END: begin
        if (!active_next) begin
          st = ST_NO_UPLOAD;
        end else begin
          if (ent.end_short) st = ST_TOO_SHORT;
          else if (cnt_a == ent.exp_size && crc_a == ent.exp_crc) st = ST_OK;
          else st = ST_MISMATCH;
          if (ent.last) begin
            active_next = 1'b0;
            crc_next    = '0;
            count_next  = '0;
          end
        end
      end
      default: ;
    endcase
    if (!ent.last) begin
      active_next = (ent.cls == CLS_CANCEL || ent.cls == CLS_START) ? 1'b0 : active;
      crc_next    = crc_a;
      count_next  = cnt_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      is_data     <= 1'b0;
      running_crc <= '0;
      count       <= '0;
      spec        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        active      <= active_next;
        is_data     <= is_data_next;
        running_crc <= crc_next;
        count       <= count_next;
        if (ent.magic) spec <= spec_next;
      end
      if (room) out_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit && room) begin
      status     <= st;
      byte_count <= cnt_a;
      crc_value  <= crc_a;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/file_put_record_checker_unit.sv -----
// Top level of the record checker: front, queue and back part.
// Depends on fprc_pkg, fprc_front, fprc_queue, fprc_back and assert_macros.svh.
//
//  Channel | Handshake           | Payload
//  input   | in_valid, in_stall  | data_byte, first_of_record, last_of_record
//  output  | out_valid, out_stall| status, byte_count, crc_value
//
// One byte per cycle when the output is not stalled; a status leaves after the last
// byte of its record, through the two-entry queue and the output register.
// Synchronous reset clears record and upload state; no clearing pass is needed.
// An output stall fills the queue, then raises in_stall.
`default_nettype none
`include "assert_macros.svh"
module file_put_record_checker_unit #(
  parameter int MAX_NAME_LEN = 192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_of_record,
  input  wire logic        last_of_record,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      byte_count,
  output logic [31:0]      crc_value
);
  import fprc_pkg::*;

  entry_t front_entry;
  entry_t head;
  logic   q_full, q_not_empty, room, push, pop;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign pop      = q_not_empty && room;

  fprc_front #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_front (
    .clk, .rst, .accept(push), .data_byte, .first_of_record, .last_of_record,
    .entry(front_entry)
  );

  fprc_queue u_queue (
    .clk, .rst, .push, .wr_entry(front_entry), .pop, .rd_entry(head),
    .full(q_full), .not_empty(q_not_empty)
  );

  fprc_back u_back (
    .clk, .rst, .pop, .ent(head), .room, .out_valid, .out_stall,
    .status, .byte_count, .crc_value
  );

  `FPRC_ASSERT_IMPL(a_no_overflow, clk, rst, push, !q_full)
  `FPRC_ASSERT_NEXT(a_result_out, clk, rst, pop && head.last && head.resp != RESP_NONE, out_valid)
  `FPRC_ASSERT_NEXT(a_no_result, clk, rst, pop && (!head.last || head.resp == RESP_NONE), !out_valid)
endmodule
`default_nettype wire
